// ----- src/gcs_pkg.sv -----
// Shared types, constants and defaults of the glyph column serializer.
package gcs_pkg;

    localparam int TABLE_ENTRIES_DEF       = 64;
    localparam int GLYPH_COLUMNS_DEF       = 8;
    localparam int ROW_LINES_DEF           = 8;
    localparam int DISPLAY_COLUMNS_MAX_DEF = 64;

    // Wide enough for a search limit of up to 256 entries.
    localparam int LIM_W       = 9;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_PRINT   = 3'd1;
    localparam logic [2:0] OP_MEASURE = 3'd2;
    localparam logic [2:0] OP_SHIFT   = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] CFG_INVERT          = 3'd0;
    localparam logic [2:0] CFG_DOT_TIME        = 3'd1;
    localparam logic [2:0] CFG_ENTRIES_IN_USE  = 3'd2;
    localparam logic [2:0] CFG_DISPLAY_COLUMNS = 3'd3;
    localparam logic [2:0] CFG_DISPLAY_ROWS    = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  entry;
        logic [15:0] code;
        logic [3:0]  glyph_width;
        logic [3:0]  glyph_height;
        logic [2:0]  column_index;
        logic [7:0]  column_bits;
        logic [6:0]  count;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  row_bits;
        logic        is_column;
        logic [15:0] hold_ticks;
        logic        found;
        logic [3:0]  width;
        logic [3:0]  height;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        invert;
        logic [15:0] dot_time;
        logic [6:0]  entries_in_use;
        logic [6:0]  display_columns;
        logic [3:0]  display_rows;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_SEARCH,
        CMD_BLANK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic             emit;       // print rather than measure
        logic [5:0]       entry;
        logic [15:0]      code;
        logic [3:0]       width;
        logic [3:0]       height;
        logic             col_ok;
        logic [2:0]       column_index;
        logic [7:0]       column_bits;
        logic [LIM_W-1:0] lim;
        logic [6:0]       blanks;
        logic             zero_hold;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COLS,
        ST_STATUS,
        ST_BLANK
    } t_state;

endpackage

// ----- src/gcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/gcs_front.sv -----
// Front end: takes input items, saturates their fields and turns them into commands.
module gcs_front #(
    parameter int TABLE_ENTRIES       = 64,
    parameter int GLYPH_COLUMNS       = 8,
    parameter int ROW_LINES           = 8,
    parameter int DISPLAY_COLUMNS_MAX = 64
) (
    input  logic              i_accept,
    input  gcs_pkg::t_in_item i_item,
    input  gcs_pkg::t_cfg     i_cfg,
    output logic              o_push,
    output gcs_pkg::t_cmd     o_cmd
);
    import gcs_pkg::*;

    localparam int COL_LIMIT = GLYPH_COLUMNS < 8 ? GLYPH_COLUMNS : 8;
    localparam int ROW_LIMIT = ROW_LINES < 8 ? ROW_LINES : 8;

    logic [LIM_W-1:0] te_x;
    logic [LIM_W-1:0] eiu_x;
    logic [6:0]       cols;
    logic [6:0]       shift_n;
    logic             entry_ok;

    always_comb begin
        te_x     = LIM_W'(TABLE_ENTRIES);
        eiu_x    = LIM_W'(i_cfg.entries_in_use);
        entry_ok = LIM_W'(i_item.entry) < te_x;
        cols     = (i_cfg.display_columns > 7'(DISPLAY_COLUMNS_MAX)) ?
                   7'(DISPLAY_COLUMNS_MAX) : i_cfg.display_columns;
        shift_n  = (i_item.count > cols) ? cols : i_item.count;

        o_cmd              = '0;
        o_cmd.kind         = CMD_LOAD;
        o_cmd.entry        = i_item.entry;
        o_cmd.code         = i_item.code;
        o_cmd.width        = (i_item.glyph_width > 4'(COL_LIMIT)) ?
                             4'(COL_LIMIT) : i_item.glyph_width;
        o_cmd.height       = (i_item.glyph_height > 4'(ROW_LIMIT)) ?
                             4'(ROW_LIMIT) : i_item.glyph_height;
        o_cmd.col_ok       = {1'b0, i_item.column_index} < 4'(COL_LIMIT);
        o_cmd.column_index = i_item.column_index;
        o_cmd.column_bits  = i_item.column_bits;
        o_cmd.lim          = (eiu_x > te_x) ? te_x : eiu_x;
        o_push             = 1'b0;

        unique case (i_item.op)
            OP_LOAD: begin
                o_cmd.kind = CMD_LOAD;
                o_push     = i_accept && entry_ok;
            end
            OP_PRINT, OP_MEASURE: begin
                o_cmd.kind = CMD_SEARCH;
                o_cmd.emit = (i_item.op == OP_PRINT);
                o_push     = i_accept;
            end
            OP_SHIFT: begin
                o_cmd.kind   = CMD_BLANK;
                o_cmd.blanks = shift_n;
                o_push       = i_accept && (shift_n != 7'd0);
            end
            OP_CLEAR: begin
                o_cmd.kind      = CMD_BLANK;
                o_cmd.blanks    = cols;
                o_cmd.zero_hold = 1'b1;
                o_push          = i_accept && (cols != 7'd0);
            end
            default: begin
                // Unused op codes are accepted and dropped.
                o_push = 1'b0;
            end
        endcase
    end
endmodule

// ----- src/gcs_queue.sv -----
// Short command queue between the front end and the execution back end.
module gcs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gcs_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output gcs_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import gcs_pkg::*;

    localparam int PW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    always_comb begin
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(r_wptr + 1'b1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(r_rptr + 1'b1);
        end
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
endmodule

// ----- src/gcs_back.sv -----
// Back end: table writes, the entry search, column emission and blank columns.
module gcs_back #(
    parameter int TABLE_ENTRIES = 64,
    parameter int GLYPH_COLUMNS = 8,
    parameter int ROW_LINES     = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gcs_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  gcs_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_strobe,
    output gcs_pkg::t_result o_result
);
    import gcs_pkg::*;

    localparam int EW        = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW        = $clog2(TABLE_ENTRIES + 1);
    localparam int GCW       = GLYPH_COLUMNS > 1 ? $clog2(GLYPH_COLUMNS) : 1;
    localparam int ROW_LIMIT = ROW_LINES < 8 ? ROW_LINES : 8;

    function automatic logic [7:0] f_drive(input logic [7:0] rows, input logic [7:0] dots,
                                           input logic [3:0] n, input logic inv);
        logic [7:0] res;
        res = rows;
        for (int r = 0; r < 8; r++) begin
            if (4'(r) < n) begin
                res[r] = dots[r] ^ inv;
            end
        end
        return res;
    endfunction

    t_state           r_state, n_state;
    logic [15:0]      r_code, n_code;
    logic             r_emit, n_emit;
    logic [LW-1:0]    r_lim, n_lim;
    logic [LW-1:0]    r_ridx, n_ridx;
    logic [LW-1:0]    r_cidx, n_cidx;
    logic [EW-1:0]    r_ent, n_ent;
    logic [3:0]       r_w, n_w;
    logic [3:0]       r_h, n_h;
    logic             r_found, n_found;
    logic [3:0]       r_col, n_col;
    logic [6:0]       r_cnt, n_cnt;
    logic [15:0]      r_hold, n_hold;
    logic [7:0]       r_rows, n_rows;
    logic             r_strobe, n_strobe;
    t_result          r_out, n_out;

    logic             tab_we, tab_re;
    logic [EW-1:0]    tab_waddr, tab_raddr;
    logic [23:0]      tab_wdata, tab_rdata;
    logic             bmp_we, bmp_re;
    logic [EW+GCW-1:0] bmp_waddr, bmp_raddr;
    logic [7:0]       bmp_rdata;
    logic [3:0]       lines;
    logic [3:0]       glyph_rows;
    logic [7:0]       rows_drv;

    // Code in the upper 16 bits, height and width in the low byte.
    gcs_ram #(.WIDTH(24), .DEPTH(1 << EW)) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_re    (tab_re),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    gcs_ram #(.WIDTH(8), .DEPTH(1 << (EW + GCW))) u_bmp (
        .i_clk   (i_clk),
        .i_we    (bmp_we),
        .i_waddr (bmp_waddr),
        .i_wdata (i_cmd.column_bits),
        .i_re    (bmp_re),
        .i_raddr (bmp_raddr),
        .o_rdata (bmp_rdata)
    );

    always_comb begin
        lines      = (i_cfg.display_rows > 4'(ROW_LIMIT)) ? 4'(ROW_LIMIT) : i_cfg.display_rows;
        glyph_rows = (r_h < lines) ? r_h : lines;

        n_state  = r_state;
        n_code   = r_code;
        n_emit   = r_emit;
        n_lim    = r_lim;
        n_ridx   = r_ridx;
        n_cidx   = r_cidx;
        n_ent    = r_ent;
        n_w      = r_w;
        n_h      = r_h;
        n_found  = r_found;
        n_col    = r_col;
        n_cnt    = r_cnt;
        n_hold   = r_hold;
        n_rows   = r_rows;
        n_strobe = 1'b0;
        n_out    = '0;
        rows_drv = r_rows;

        o_pop     = 1'b0;
        tab_we    = 1'b0;
        tab_waddr = EW'(i_cmd.entry);
        tab_wdata = {i_cmd.code, i_cmd.height, i_cmd.width};
        tab_re    = 1'b0;
        tab_raddr = r_ridx[EW-1:0];
        bmp_we    = 1'b0;
        bmp_waddr = {EW'(i_cmd.entry), GCW'(i_cmd.column_index)};
        bmp_re    = 1'b0;
        bmp_raddr = {r_ent, GCW'(r_col)};

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_LOAD: begin
                            tab_we = 1'b1;
                            bmp_we = i_cmd.col_ok;
                        end
                        CMD_SEARCH: begin
                            n_code = i_cmd.code;
                            n_emit = i_cmd.emit;
                            n_lim  = LW'(i_cmd.lim);
                            if (i_cmd.lim == '0) begin
                                n_found = 1'b0;
                                n_w     = '0;
                                n_h     = '0;
                                n_state = ST_STATUS;
                            end else begin
                                tab_re    = 1'b1;
                                tab_raddr = '0;
                                n_ridx    = LW'(1);
                                n_cidx    = '0;
                                n_state   = ST_SEARCH;
                            end
                        end
                        CMD_BLANK: begin
                            n_cnt   = i_cmd.blanks;
                            n_hold  = i_cmd.zero_hold ? 16'd0 : i_cfg.dot_time;
                            n_state = ST_BLANK;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // The read issued last cycle returns entry r_cidx; the next is issued now.
                tab_re = 1'b1;
                n_ridx = LW'(r_ridx + 1'b1);
                n_cidx = LW'(r_cidx + 1'b1);
                if (tab_rdata[23:8] == r_code) begin
                    n_found = 1'b1;
                    n_w     = tab_rdata[3:0];
                    n_h     = tab_rdata[7:4];
                    n_ent   = r_cidx[EW-1:0];
                    if (r_emit && (tab_rdata[3:0] != 4'd0)) begin
                        bmp_re    = 1'b1;
                        bmp_raddr = {r_cidx[EW-1:0], GCW'(0)};
                        n_col     = '0;
                        n_state   = ST_COLS;
                    end else begin
                        n_state = ST_STATUS;
                    end
                end else if (r_cidx == LW'(r_lim - 1'b1)) begin
                    n_found = 1'b0;
                    n_w     = '0;
                    n_h     = '0;
                    n_state = ST_STATUS;
                end
            end
            ST_COLS: begin
                rows_drv           = f_drive(r_rows, bmp_rdata, glyph_rows, i_cfg.invert);
                n_rows             = rows_drv;
                n_strobe           = 1'b1;
                n_out.row_bits     = rows_drv;
                n_out.is_column    = 1'b1;
                n_out.hold_ticks   = i_cfg.dot_time;
                if (r_col == 4'(r_w - 1'b1)) begin
                    n_state = ST_STATUS;
                end else begin
                    bmp_re    = 1'b1;
                    bmp_raddr = {r_ent, GCW'(r_col + 4'd1)};
                    n_col     = 4'(r_col + 4'd1);
                end
            end
            ST_STATUS: begin
                n_strobe       = 1'b1;
                n_out.row_bits = r_rows;
                n_out.found    = r_found;
                n_out.width    = r_w;
                n_out.height   = r_h;
                n_out.last     = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_BLANK: begin
                rows_drv         = f_drive(r_rows, 8'd0, lines, i_cfg.invert);
                n_rows           = rows_drv;
                n_strobe         = 1'b1;
                n_out.row_bits   = rows_drv;
                n_out.is_column  = 1'b1;
                n_out.hold_ticks = r_hold;
                n_out.last       = (r_cnt == 7'd1);
                n_cnt            = 7'(r_cnt - 1'b1);
                if (r_cnt == 7'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rows   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rows   <= n_rows;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_emit  <= n_emit;
        r_lim   <= n_lim;
        r_ridx  <= n_ridx;
        r_cidx  <= n_cidx;
        r_ent   <= n_ent;
        r_w     <= n_w;
        r_h     <= n_h;
        r_found <= n_found;
        r_col   <= n_col;
        r_cnt   <= n_cnt;
        r_hold  <= n_hold;
        r_out   <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;
endmodule

// ----- src/glyph_column_serializer.sv -----
// Top level of the dot-matrix glyph column serializer.
//
// Usage: an item is taken at a rising edge with start high and busy low. Load
// items write one glyph table entry (code, size, one bitmap column) and give no
// result. Print searches the first entries_in_use entries for the code, emits
// one column result per glyph column and closes with a status result; measure
// gives the status alone. Shift and clear emit blank columns.
// Results appear on o_result for one cycle, marked by o_strobe; the receiver
// cannot stall them. The configuration port writes a register whenever
// i_cfg_we is high.
// Items pass a two-deep command queue; the execution unit picks a command up
// only when idle. The search reads one table entry per cycle from a single
// RAM port, so a print takes longer the more entries it scans and the wider
// the glyph. busy is high while the queue is full.
// Reset clears the queue, the driven row levels and the registers to their
// defaults; table contents are undefined until loaded.
module glyph_column_serializer #(
    parameter int TABLE_ENTRIES       = gcs_pkg::TABLE_ENTRIES_DEF,
    parameter int GLYPH_COLUMNS       = gcs_pkg::GLYPH_COLUMNS_DEF,
    parameter int ROW_LINES           = gcs_pkg::ROW_LINES_DEF,
    parameter int DISPLAY_COLUMNS_MAX = gcs_pkg::DISPLAY_COLUMNS_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  gcs_pkg::t_in_item i_item,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_wdata,
    output logic             o_strobe,
    output gcs_pkg::t_result o_result
);
    import gcs_pkg::*;

    t_cfg r_cfg;
    logic accept;
    logic push;
    t_cmd push_cmd;
    logic q_full, q_valid, q_pop;
    t_cmd q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert          <= 1'b0;
            r_cfg.dot_time        <= 16'd1;
            r_cfg.entries_in_use  <= 7'd0;
            r_cfg.display_columns <= 7'd32;
            r_cfg.display_rows    <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INVERT:          r_cfg.invert          <= i_cfg_wdata[0];
                CFG_DOT_TIME:        r_cfg.dot_time        <= i_cfg_wdata;
                CFG_ENTRIES_IN_USE:  r_cfg.entries_in_use  <= i_cfg_wdata[6:0];
                CFG_DISPLAY_COLUMNS: r_cfg.display_columns <= i_cfg_wdata[6:0];
                CFG_DISPLAY_ROWS:    r_cfg.display_rows    <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign busy   = q_full;
    assign accept = start && !q_full;

    gcs_front #(
        .TABLE_ENTRIES       (TABLE_ENTRIES),
        .GLYPH_COLUMNS       (GLYPH_COLUMNS),
        .ROW_LINES           (ROW_LINES),
        .DISPLAY_COLUMNS_MAX (DISPLAY_COLUMNS_MAX)
    ) u_front (
        .i_accept (accept),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    gcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    gcs_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .GLYPH_COLUMNS (GLYPH_COLUMNS),
        .ROW_LINES     (ROW_LINES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (q_valid),
        .i_cmd    (q_cmd),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );
endmodule

// ----- src/gcs_checker.sv -----
// Port-level checks of the glyph column serializer and their binding.
module gcs_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input gcs_pkg::t_in_item i_item,
    input logic             i_cfg_we,
    input logic [2:0]       i_cfg_index,
    input logic [15:0]      i_cfg_wdata,
    input logic             o_strobe,
    input gcs_pkg::t_result o_result
);
    import gcs_pkg::*;

    // Nothing comes out in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.is_column |-> o_result.last && o_result.hold_ticks == 16'd0)
        else $error("status item is not the last one of its command");

    a_column_has_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.is_column |->
            !o_result.found && o_result.width == 4'd0 && o_result.height == 4'd0)
        else $error("column item carries status fields");

    // A miss reports an empty glyph size.
    a_miss_has_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.is_column && !o_result.found |->
            o_result.width == 4'd0 && o_result.height == 4'd0)
        else $error("not-found status with a glyph size");
endmodule

bind glyph_column_serializer gcs_checker u_gcs_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the glyph column serializer with a scoreboard class.
import gcs_pkg::*;

localparam int TABLE_N = TABLE_ENTRIES_DEF;
localparam int COLS_N  = (GLYPH_COLUMNS_DEF < 8) ? GLYPH_COLUMNS_DEF : 8;
localparam int ROWS_N  = (ROW_LINES_DEF < 8) ? ROW_LINES_DEF : 8;
localparam int SHIFT_N = DISPLAY_COLUMNS_MAX_DEF;

class glyph_scoreboard;
    logic [15:0] glyph_code [TABLE_N];
    logic [3:0]  glyph_w [TABLE_N];
    logic [3:0]  glyph_h [TABLE_N];
    logic [7:0]  glyph_cols [TABLE_N][8];
    bit          col_loaded [TABLE_N][8];
    logic [7:0]  row_levels;
    bit          invert;
    logic [15:0] dot_time;
    int unsigned entries_in_use;
    int unsigned display_columns;
    int unsigned display_rows;
    t_result     column_results [$];
    int          mismatches;

    function new();
        row_levels      = '0;
        invert          = 1'b0;
        dot_time        = 16'd1;
        entries_in_use  = 0;
        display_columns = 32;
        display_rows    = 8;
        mismatches      = 0;
    endfunction

    task flag_error(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function int pending();
        return column_results.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            CFG_INVERT:          invert = data[0];
            CFG_DOT_TIME:        dot_time = data;
            CFG_ENTRIES_IN_USE:  entries_in_use = data[6:0];
            CFG_DISPLAY_COLUMNS: display_columns = data[6:0];
            CFG_DISPLAY_ROWS:    display_rows = data[3:0];
            default: ;
        endcase
    endfunction

    function int find_entry(logic [15:0] code);
        int lim;
        lim = (entries_in_use > TABLE_N) ? TABLE_N : entries_in_use;
        for (int i = 0; i < lim; i++)
            if (glyph_code[i] == code)
                return i;
        return -1;
    endfunction

    // A print may only touch bitmap columns that were loaded at some point.
    function bit print_safe(logic [15:0] code);
        int e;
        e = find_entry(code);
        if (e < 0)
            return 1'b1;
        for (int c = 0; c < glyph_w[e]; c++)
            if (!col_loaded[e][c])
                return 1'b0;
        return 1'b1;
    endfunction

    function int rows_present();
        return (display_rows > ROWS_N) ? ROWS_N : display_rows;
    endfunction

    function void drive_rows(int n, logic [7:0] dots);
        for (int r = 0; r < n && r < ROWS_N; r++)
            row_levels[r] = dots[r] ^ invert;
    endfunction

    function void push_result(bit col, logic [15:0] hold, bit fnd, logic [3:0] w,
                              logic [3:0] h, bit lst);
        t_result res;
        res.row_bits   = row_levels;
        res.is_column  = col;
        res.hold_ticks = hold;
        res.found      = fnd;
        res.width      = w;
        res.height     = h;
        res.last       = lst;
        column_results.push_back(res);
    endfunction

    function void blank_run(int n, logic [15:0] hold);
        for (int i = 0; i < n; i++) begin
            drive_rows(rows_present(), 8'h00);
            push_result(1'b1, hold, 1'b0, 4'd0, 4'd0, i == n - 1);
        end
    endfunction

    function void apply_item(t_in_item it);
        int         e;
        int         n;
        int         cols;
        int         cnt;
        logic [3:0] w;
        logic [3:0] h;
        cols = (display_columns > SHIFT_N) ? SHIFT_N : display_columns;
        case (it.op)
            OP_LOAD: begin
                w = (it.glyph_width > COLS_N) ? 4'(COLS_N) : it.glyph_width;
                h = (it.glyph_height > ROWS_N) ? 4'(ROWS_N) : it.glyph_height;
                glyph_code[it.entry] = it.code;
                glyph_w[it.entry]    = w;
                glyph_h[it.entry]    = h;
                if (it.column_index < COLS_N) begin
                    glyph_cols[it.entry][it.column_index] = it.column_bits;
                    col_loaded[it.entry][it.column_index] = 1'b1;
                end
            end
            OP_PRINT, OP_MEASURE: begin
                e = find_entry(it.code);
                w = (e >= 0) ? glyph_w[e] : 4'd0;
                h = (e >= 0) ? glyph_h[e] : 4'd0;
                if (e >= 0 && it.op == OP_PRINT) begin
                    n = rows_present();
                    if (h < n)
                        n = h;
                    for (int c = 0; c < w && c < COLS_N; c++) begin
                        drive_rows(n, glyph_cols[e][c]);
                        push_result(1'b1, dot_time, 1'b0, 4'd0, 4'd0, 1'b0);
                    end
                end
                push_result(1'b0, 16'd0, e >= 0, w, h, 1'b1);
            end
            OP_SHIFT: begin
                cnt = (it.count > cols) ? cols : it.count;
                blank_run(cnt, dot_time);
            end
            OP_CLEAR: blank_run(cols, 16'd0);
            default: ;
        endcase
    endfunction

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task check_result(t_result got);
        t_result want;
        if (column_results.size() == 0) begin
            flag_error($sformatf("result %h arrived with nothing outstanding", got));
            return;
        end
        want = column_results.pop_front();
        compare_field("row_bits", got.row_bits, want.row_bits);
        compare_field("is_column", got.is_column, want.is_column);
        compare_field("hold_ticks", got.hold_ticks, want.hold_ticks);
        compare_field("found", got.found, want.found);
        compare_field("width", got.width, want.width);
        compare_field("height", got.height, want.height);
        compare_field("last", got.last, want.last);
    endtask
endclass

module tb;

    localparam logic [2:0]   OP_UNUSED_LO  = 3'd5;
    localparam logic [2:0]   OP_UNUSED_HI  = 3'd7;
    localparam logic [2:0]   CFG_SPARE     = 3'd7;
    localparam int           DRAIN_CYCLES  = 100;
    localparam int           TIMEOUT_UNITS = 4_000_000;
    localparam logic [63:0]  DIRECTED_DOTS = {8'hF0, 8'h0F, 8'h7E, 8'h81,
                                              8'h55, 8'hAA, 8'h00, 8'hFF};
    localparam logic [127:0] CODE_POOL     = {16'h0000, 16'hFFFF, 16'h0041, 16'h8000,
                                              16'h7FFF, 16'h1234, 16'h00FF, 16'hAAAA};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_in_item    i_item      = '0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_strobe;
    t_result     o_result;

    glyph_scoreboard sb = new();
    int gap_pct        = 29;
    int accepted_items = 0;

    glyph_column_serializer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_result);
    end

    function automatic t_in_item random_item();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    function automatic logic [15:0] random_code();
        if ($urandom_range(0, 3) != 0)
            return CODE_POOL[16*$urandom_range(0, 7) +: 16];
        return 16'($urandom());
    endfunction

    task automatic send_item(input t_in_item it);
        // A print that would reach a never-loaded bitmap column is sent as a measure.
        if (it.op == OP_PRINT && !sb.print_safe(it.code))
            it.op = OP_MEASURE;
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < gap_pct);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.apply_item(it);
        if (it.op <= OP_CLEAR)
            accepted_items++;
    endtask

    task automatic send_lookup(input logic [2:0] op, input logic [15:0] code);
        t_in_item it;
        it      = random_item();
        it.op   = op;
        it.code = code;
        send_item(it);
    endtask

    task automatic send_blank(input logic [2:0] op, input logic [6:0] count);
        t_in_item it;
        it       = random_item();
        it.op    = op;
        it.count = count;
        send_item(it);
    endtask

    task automatic send_load(input logic [5:0] entry, input logic [15:0] code,
                             input logic [3:0] w, input logic [3:0] h,
                             input logic [2:0] col, input logic [7:0] dots);
        t_in_item it;
        it              = random_item();
        it.op           = OP_LOAD;
        it.entry        = entry;
        it.code         = code;
        it.glyph_width  = w;
        it.glyph_height = h;
        it.column_index = col;
        it.column_bits  = dots;
        send_item(it);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Unused upper data bits carry junk, since every register but dot_time takes only its low bits.
    task automatic apply_config(input bit inv, input logic [15:0] dots,
                                input logic [6:0] entries, input logic [6:0] columns,
                                input logic [3:0] rows);
        logic [2:0]  idx [6];
        logic [15:0] val [6];
        logic [31:0] junk;
        junk   = $urandom();
        idx[0] = CFG_INVERT;          val[0] = {junk[14:0], inv};
        idx[1] = CFG_DOT_TIME;        val[1] = dots;
        idx[2] = CFG_ENTRIES_IN_USE;  val[2] = {junk[31:23], entries};
        idx[3] = CFG_DISPLAY_COLUMNS; val[3] = {junk[22:14], columns};
        idx[4] = CFG_DISPLAY_ROWS;    val[4] = {junk[11:0], rows};
        idx[5] = CFG_SPARE;           val[5] = 16'($urandom());
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_wdata <= val[i];
            @(posedge i_clk);
            sb.write_reg(idx[i], val[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_sequence();
        int         sel;
        int         n;
        logic [5:0] e;
        logic [15:0] code;
        logic [3:0] w;
        logic [3:0] h;
        t_in_item   it;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            // Glyph definition: each column of one entry, sometimes a stray one, maybe a print.
            e    = 6'($urandom());
            code = random_code();
            w    = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8));
            h    = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 8));
            n    = (w > COLS_N) ? COLS_N : w;
            for (int c = 0; c < n; c++)
                send_load(e, code, w, h, 3'(c), 8'($urandom()));
            if ($urandom_range(0, 3) == 0)
                send_load(e, code, w, h, 3'($urandom()), 8'($urandom()));
            if ($urandom_range(0, 1) == 1)
                send_lookup(OP_PRINT, code);
        end else if (sel < 38) begin
            repeat ($urandom_range(1, 3)) begin
                it    = random_item();
                it.op = OP_LOAD;
                send_item(it);
            end
        end else if (sel < 65) begin
            send_lookup(OP_PRINT, random_code());
        end else if (sel < 75) begin
            send_lookup(OP_MEASURE, random_code());
        end else if (sel < 87) begin
            if ($urandom_range(0, 3) == 0)
                send_blank(OP_SHIFT, 7'($urandom_range(0, 127)));
            else
                send_blank(OP_SHIFT, 7'($urandom_range(0, 8)));
        end else if (sel < 93) begin
            send_blank(OP_CLEAR, 7'($urandom()));
        end else begin
            it    = random_item();
            it.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            send_item(it);
        end
    endtask

    initial begin
        #(TIMEOUT_UNITS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int target;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apply_config(1'b0, 16'd7, 7'd0, 7'd32, 4'd8);

        // Empty search, zero and clamped shifts, a full clear and an unused op.
        send_lookup(OP_PRINT, 16'h0041);
        send_lookup(OP_MEASURE, 16'hFFFF);
        send_blank(OP_SHIFT, 7'd0);
        send_blank(OP_SHIFT, 7'd5);
        send_blank(OP_SHIFT, 7'd127);
        send_blank(OP_CLEAR, 7'd0);
        send_blank(OP_UNUSED_HI, 7'd9);

        // Entry 0 has its size saturated, entry 1 is zero-sized, entry 2 is short.
        for (int c = 0; c < 8; c++)
            send_load(6'd0, 16'hFFFF, 4'd15, 4'd15, 3'(c), DIRECTED_DOTS[8*c +: 8]);
        send_load(6'd1, 16'h0000, 4'd0, 4'd0, 3'd7, 8'hFF);
        send_load(6'd2, 16'h1234, 4'd3, 4'd2, 3'd0, 8'h81);
        send_load(6'd2, 16'h1234, 4'd3, 4'd2, 3'd1, 8'h42);
        send_load(6'd2, 16'h1234, 4'd3, 4'd2, 3'd2, 8'h24);

        wait_idle();
        apply_config(1'b1, 16'hFFFF, 7'd3, 7'd0, 4'd15);
        send_lookup(OP_PRINT, 16'hFFFF);
        send_lookup(OP_PRINT, 16'h0000);
        send_lookup(OP_PRINT, 16'h1234);
        send_lookup(OP_MEASURE, 16'h1234);
        send_lookup(OP_PRINT, 16'h5555);
        send_blank(OP_CLEAR, 7'd0);
        send_blank(OP_SHIFT, 7'd3);

        // Give every remaining entry a one-column glyph so that any search limit is safe.
        for (int e = 3; e < TABLE_N; e++)
            send_load(6'(e), random_code(), 4'd1, 4'($urandom()), 3'd0, 8'($urandom()));

        for (int p = 0; p < 3; p++) begin
            wait_idle();
            case (p)
                0: begin
                    gap_pct = 29;
                    apply_config(1'b0, 16'($urandom()), 7'd64, 7'd64, 4'd1);
                end
                1: begin
                    gap_pct = 84;
                    apply_config(1'b1, 16'd0, 7'd127, 7'd127, 4'd0);
                end
                default: begin
                    gap_pct = 0;
                    apply_config(1'($urandom()), 16'($urandom()), 7'($urandom_range(1, 64)),
                                 7'($urandom_range(1, 20)), 4'($urandom_range(1, 8)));
                end
            endcase
            target = accepted_items + 30;
            while (accepted_items < target)
                random_sequence();
        end

        wait_idle();
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- glyph_column_serializer.f -----
src/gcs_pkg.sv
src/gcs_ram.sv
src/gcs_front.sv
src/gcs_queue.sv
src/gcs_back.sv
src/glyph_column_serializer.sv
src/gcs_checker.sv
tb/sv/tb.sv
